@@ hdl/lsc_pkg.sv @@
package lsc_pkg;

    localparam int DEF_MAX_SETS  = 2048;
    localparam int DEF_MAX_WAYS  = 8;
    localparam int DEF_ADDR_BITS = 32;

    localparam int ADDR_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAY_COUNT   = 2'd2;

    localparam logic [2:0] OFFSET_RESET = 3'd3;
    localparam logic [2:0] OFFSET_MIN   = 3'd3;
    localparam logic [3:0] INDEX_RESET  = 4'd7;
    localparam logic [3:0] WAYS_RESET   = 4'd1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } lsc_state_t;

    typedef struct packed {
        logic clr_we;
        logic accept;
        logic commit;
    } lsc_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } lsc_status_t;

endpackage

@@ hdl/lsc_ctrl.sv @@
module lsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lsc_pkg::lsc_status_t status,
    output lsc_pkg::lsc_cmd_t    cmd
);
    import lsc_pkg::*;

    lsc_state_t state_reg;
    lsc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                // hold the item until the output register is free
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ hdl/lsc_dp.sv @@
module lsc_dp #(
    parameter int MAX_SETS  = lsc_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS  = lsc_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = lsc_pkg::DEF_ADDR_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lsc_pkg::lsc_cmd_t             cmd,
    output lsc_pkg::lsc_status_t          status,
    input  logic [lsc_pkg::ADDR_W-1:0]    address,
    input  logic                          is_store,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic                          dirty_eviction,
    input  logic                          cfg_valid,
    input  logic [lsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lsc_pkg::*;

    localparam int EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int TAG_W    = EFF_BITS - 3;
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WC_W     = $clog2(MAX_WAYS + 1);
    localparam int IDX_MAX  = $clog2(MAX_SETS + 1) - 1;

    typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;
    typedef logic [MAX_WAYS-1:0][WAY_W-1:0] rec_row_t;
    typedef struct packed {
        logic [MAX_WAYS-1:0] valid;
        logic [MAX_WAYS-1:0] dirty;
        rec_row_t            rec;
    } st_row_t;

    tag_row_t tag_mem [MAX_SETS];
    st_row_t  st_mem  [MAX_SETS];

    logic [2:0]       offset_bits_reg;
    logic [3:0]       index_bits_reg;
    logic [3:0]       way_count_reg;
    logic [SET_W-1:0] clr_cnt_reg;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             store_reg;
    tag_row_t         tag_rd_reg;
    st_row_t          st_rd_reg;
    logic             out_valid_reg;
    logic             hit_reg;
    logic             dirty_ev_reg;

    logic [EFF_BITS-1:0] eff_addr;
    logic [2:0]          off_eff;
    logic [4:0]          idx_eff;
    logic [TAG_W-1:0]    baddr;
    logic [TAG_W-1:0]    set_mask;
    logic [SET_W-1:0]    set_in;
    logic [TAG_W-1:0]    tag_in;
    logic [WC_W-1:0]     ways_eff;
    st_row_t             clr_row;

    logic                found;
    logic [WAY_W-1:0]    hit_pos;
    logic [WAY_W-1:0]    vic_pos;
    logic [WAY_W-1:0]    sel_pos;
    logic [WAY_W-1:0]    sel_way;
    tag_row_t            tag_wr;
    st_row_t             st_wr;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_RESET;
            index_bits_reg  <= INDEX_RESET;
            way_count_reg   <= WAYS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[2:0];
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                CFG_WAY_COUNT:   way_count_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // address split
    always_comb
    begin
        eff_addr = address[EFF_BITS-1:0];
        off_eff  = (offset_bits_reg < OFFSET_MIN) ? OFFSET_MIN : offset_bits_reg;
        idx_eff  = (index_bits_reg > IDX_MAX) ? 5'(IDX_MAX) : {1'b0, index_bits_reg};
        baddr    = TAG_W'(eff_addr >> off_eff);
        set_mask = ~(~TAG_W'(0) << idx_eff);
        set_in   = SET_W'(baddr & set_mask);
        tag_in   = baddr >> idx_eff;
        if (way_count_reg == 4'd0)
        begin
            ways_eff = WC_W'(1);
        end
        else if (way_count_reg > MAX_WAYS)
        begin
            ways_eff = WC_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WC_W'(way_count_reg);
        end
    end

    always_comb
    begin
        clr_row.valid = '0;
        clr_row.dirty = '0;
        for (int p = 0; p < MAX_WAYS; p++)
        begin
            clr_row.rec[p] = WAY_W'(p);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_we)
        begin
            clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
        end
    end

    assign status.clr_last = (clr_cnt_reg == SET_W'(MAX_SETS - 1));

    // lookup over the registered rows, then promote
    always_comb
    begin
        found   = 1'b0;
        hit_pos = '0;
        vic_pos = WAY_W'(ways_eff - WC_W'(1));
        for (int p = MAX_WAYS - 1; p >= 0; p--)
        begin
            if (p < ways_eff && st_rd_reg.valid[st_rd_reg.rec[p]]
                && tag_rd_reg[st_rd_reg.rec[p]] == tag_reg)
            begin
                found   = 1'b1;
                hit_pos = WAY_W'(p);
            end
        end
        for (int p = 0; p < MAX_WAYS; p++)
        begin
            if (p < ways_eff && !st_rd_reg.valid[st_rd_reg.rec[p]])
            begin
                vic_pos = WAY_W'(p);
            end
        end
        sel_pos = found ? hit_pos : vic_pos;
        sel_way = st_rd_reg.rec[sel_pos];

        tag_wr = tag_rd_reg;
        st_wr  = st_rd_reg;
        if (found)
        begin
            st_wr.dirty[sel_way] = st_rd_reg.dirty[sel_way] | store_reg;
        end
        else
        begin
            tag_wr[sel_way]      = tag_reg;
            st_wr.valid[sel_way] = 1'b1;
            st_wr.dirty[sel_way] = store_reg;
        end
        st_wr.rec[0] = sel_way;
        for (int p = 1; p < MAX_WAYS; p++)
        begin
            if (p <= sel_pos)
            begin
                st_wr.rec[p] = st_rd_reg.rec[p-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            set_reg    <= set_in;
            tag_reg    <= tag_in;
            store_reg  <= is_store;
            tag_rd_reg <= tag_mem[set_in];
            st_rd_reg  <= st_mem[set_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_we)
        begin
            st_mem[clr_cnt_reg] <= clr_row;
        end
        else if (cmd.commit)
        begin
            st_mem[set_reg] <= st_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            tag_mem[set_reg] <= tag_wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg      <= found;
            dirty_ev_reg <= !found && st_rd_reg.valid[sel_way] && st_rd_reg.dirty[sel_way];
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign dirty_eviction  = dirty_ev_reg;

endmodule

@@ hdl/lru_set_assoc_cache_tags.sv @@
// Channel  | Handshake            | Payload
// in       | in_valid/in_ready    | address, is_store
// out      | out_valid/out_ready  | hit, dirty_eviction
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// The set rows are read from block memory into registers on accept, then
// compared, updated and written back once the output register is free; a new
// item is not taken until the one before it has been written back.
// After reset the state memory is swept one set a cycle, all MAX_SETS sets, with
// in_ready low; configuration writes are taken throughout (cfg_ready is high).
// A result waiting in the output register stalls the next item at its update.
module lru_set_assoc_cache_tags #(
    parameter int MAX_SETS  = lsc_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS  = lsc_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = lsc_pkg::DEF_ADDR_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lsc_pkg::ADDR_W-1:0]     address,
    input  logic                           is_store,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    output logic                           dirty_eviction,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lsc_pkg::*;

    lsc_cmd_t    cmd;
    lsc_status_t status;

    assign cfg_ready = 1'b1;

    lsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lsc_dp #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .address        (address),
        .is_store       (is_store),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .dirty_eviction (dirty_eviction),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

endmodule

@@ hdl/lsc_chk.sv @@
module lsc_chk (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic hit,
    input logic dirty_eviction
);

    // a hit never reports a write-back
    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !dirty_eviction)
        else $error("dirty eviction flagged on hit");

    // one item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(dirty_eviction))
        else $error("stalled result changed");

endmodule

bind lru_set_assoc_cache_tags lsc_chk u_lsc_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .dirty_eviction (dirty_eviction)
);

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lsc_pkg::*;

    localparam int NSETS = DEF_MAX_SETS;
    localparam int NWAYS = DEF_MAX_WAYS;
    localparam int MAX_IDX = 11;
    localparam int CYCLE_LIMIT = 400000;

    class cache_scoreboard;
        logic [31:0] tags [NSETS*NWAYS];
        bit          valid [NSETS*NWAYS];
        bit          dirty [NSETS*NWAYS];
        int unsigned order [NSETS][NWAYS];
        int unsigned offset_bits;
        int unsigned index_bits;
        int unsigned way_count;
        bit          hit_q [$];
        bit          evict_q [$];
        int          errors;

        function new();
            for (int s = 0; s < NSETS; s++)
            begin
                for (int w = 0; w < NWAYS; w++)
                begin
                    valid[s*NWAYS+w] = 0;
                    dirty[s*NWAYS+w] = 0;
                    tags[s*NWAYS+w] = '0;
                    order[s][w] = w;
                end
            end
            offset_bits = OFFSET_RESET;
            index_bits = INDEX_RESET;
            way_count = WAYS_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OFFSET_BITS: offset_bits = data[2:0];
                CFG_INDEX_BITS:  index_bits = data;
                CFG_WAY_COUNT:   way_count = data;
                default: ;
            endcase
        endfunction

        function void to_front(int unsigned s, int unsigned pos);
            int unsigned w;
            w = order[s][pos];
            for (int p = pos; p > 0; p--)
                order[s][p] = order[s][p-1];
            order[s][0] = w;
        endfunction

        function void note_access(logic [31:0] addr, bit st);
            int unsigned off, idx, ways, s, e, victim;
            logic [31:0] blk, tag;
            bit found;
            off = offset_bits < OFFSET_MIN ? OFFSET_MIN : offset_bits;
            idx = index_bits > MAX_IDX ? MAX_IDX : index_bits;
            ways = way_count == 0 ? 1 : (way_count > NWAYS ? NWAYS : way_count);
            blk = addr >> off;
            s = blk & ((32'd1 << idx) - 1);
            tag = blk >> idx;
            found = 0;
            for (int p = 0; p < ways && !found; p++)
            begin
                e = s*NWAYS + order[s][p];
                if (valid[e] && tags[e] == tag)
                begin
                    found = 1;
                    if (st)
                        dirty[e] = 1;
                    to_front(s, p);
                end
            end
            if (found)
            begin
                hit_q.push_back(1);
                evict_q.push_back(0);
                return;
            end
            victim = ways - 1;
            for (int p = ways; p > 0; p--)
            begin
                if (!valid[s*NWAYS + order[s][p-1]])
                begin
                    victim = p - 1;
                    break;
                end
            end
            e = s*NWAYS + order[s][victim];
            hit_q.push_back(0);
            evict_q.push_back(valid[e] && dirty[e]);
            tags[e] = tag;
            valid[e] = 1;
            dirty[e] = st;
            to_front(s, victim);
        endfunction

        function void check_result(bit h, bit d);
            bit eh, ed;
            if (hit_q.size() == 0)
            begin
                report_error("result with nothing expected");
                return;
            end
            eh = hit_q.pop_front();
            ed = evict_q.pop_front();
            if (h !== eh)
                report_error($sformatf("hit %0b, want %0b", h, eh));
            if (d !== ed)
                report_error($sformatf("dirty_eviction %0b, want %0b", d, ed));
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= 50)
                $display("ERROR %0t: %s", $realtime, msg);
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_ready, is_store;
    logic [ADDR_W-1:0] address;
    logic out_valid, out_ready, hit, dirty_eviction;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cache_scoreboard sb;
    int  cycles;
    int  idle_pct;
    bit  hold_off;

    lru_set_assoc_cache_tags u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .address(address), .is_store(is_store),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .dirty_eviction(dirty_eviction),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout");
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // sample results and check each one taken at the output
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(hit, dirty_eviction);
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // valid stays up between items unless the sender idles
    task automatic send_access(logic [31:0] addr, bit st);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        address <= addr;
        is_store <= st;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_access(addr, st);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.hit_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_geometry(int unsigned off, int unsigned idx, int unsigned ways);
        drain();
        write_cfg(CFG_OFFSET_BITS, CFG_DATA_W'(off));
        write_cfg(CFG_INDEX_BITS, CFG_DATA_W'(idx));
        write_cfg(CFG_WAY_COUNT, CFG_DATA_W'(ways));
        cfg_valid <= 1'b0;
    endtask

    // reuse a small pool of lines so that hits and evictions happen often
    function automatic logic [31:0] pool_addr(logic [31:0] base);
        logic [31:0] a;
        a = base + ($urandom_range(15) << sb.offset_bits) +
            ($urandom_range(5) << (sb.offset_bits + sb.index_bits));
        return a ^ $urandom_range(7);
    endfunction

    initial
    begin
        logic [31:0] base;
        sb = new();
        hold_off = 0;
        idle_pct = 23;
        in_valid = 0;
        address = '0;
        is_store = 0;
        cfg_valid = 0;
        cfg_index = CFG_OFFSET_BITS;
        cfg_data = '0;
        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and reset geometry, direct mapped
        send_access(32'h0000_0000, 1);
        send_access(32'h0000_0000, 0);
        send_access(32'hFFFF_FFFF, 1);
        send_access(32'hFFFF_FFF8, 0);
        send_access(32'h0000_0400, 0);
        send_access(32'h0000_0000, 1);
        send_access(32'h0000_0400, 1);
        // out-of-range settings: clamp of offset, index and ways
        set_geometry(0, 15, 0);
        send_access(32'h0000_0000, 1);
        send_access(32'h0000_4000, 1);
        send_access(32'h0000_0000, 0);
        set_geometry(7, 0, 15);
        for (int i = 0; i < 10; i++)
            send_access(i << 7, i[0]);
        send_access(32'h0, 0);
        // shrink, overwrite, then grow so hidden lines and duplicate tags show
        set_geometry(7, 0, 2);
        send_access(32'h0000_0500, 1);
        send_access(32'h0000_0580, 0);
        set_geometry(7, 0, 8);
        send_access(32'h0000_0500, 0);
        send_access(32'h0000_0200, 0);

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: set_geometry(3, 0, 1);
                1: set_geometry(7, 11, 8);
                2: set_geometry(4, 2, 4);
                default: set_geometry($urandom_range(7), $urandom_range(15),
                                      $urandom_range(15));
            endcase
            idle_pct = (ph == 4) ? 0 : 23;
            base = $urandom;
            if (ph == 5)
            begin
                fork
                    begin
                        hold_off = 1;
                        repeat (60) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int i = 0; i < 72; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_access($urandom, $urandom_range(1));
                else
                    send_access(pool_addr(base), $urandom_range(1));
            end
            if (ph == 6)
                drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
